// File: src/rotate_point_about_center_core_macros.svh
// Assertion macros shared by the rotate-point RTL modules.
`ifndef ROTATE_POINT_ABOUT_CENTER_CORE_MACROS_SVH
`define ROTATE_POINT_ABOUT_CENTER_CORE_MACROS_SVH

// Same-cycle implication, off during reset
`define RPAC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rpac assertion failed");

// Next-cycle implication, off during reset
`define RPAC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rpac assertion failed");

`endif

// File: src/rpac_pkg.sv
// Shared types, widths and CORDIC constants for the rotate-point core.
package rpac_pkg;

    // Field widths
    localparam int CW = 32;             // Q16.16 coordinate
    localparam int AW = 19;             // Q3.16 angle
    localparam int DW = CW + 1;         // exact coordinate difference
    localparam int QW = 35;             // Q30 CORDIC datapath word

    // Stream widths
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 72;

    // Defaults for top-level parameters
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int FRAC_BITS_DEF     = 16;

    // Q30 constants
    localparam logic signed [QW-1:0] Q30_PI       = 35'sd3373259426;
    localparam logic signed [QW-1:0] Q30_HALF_PI  = 35'sd1686629713;
    localparam logic signed [QW-1:0] Q30_GAIN_INV = 35'sd652032874;

    // Payload handed from cell to cell
    typedef struct packed {
        logic                   neg;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic signed [QW-1:0]   x;
        logic signed [QW-1:0]   y;
        logic signed [QW-1:0]   z;
    } t_cell;

    // atan(2^-i) in Q30
    function automatic logic signed [QW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [QW-1:0] v;
        case (idx)
            5'd0:    v = 35'sd843314857;
            5'd1:    v = 35'sd497837829;
            5'd2:    v = 35'sd263043837;
            5'd3:    v = 35'sd133525159;
            5'd4:    v = 35'sd67021687;
            5'd5:    v = 35'sd33543516;
            5'd6:    v = 35'sd16775851;
            5'd7:    v = 35'sd8388437;
            5'd8:    v = 35'sd4194283;
            5'd9:    v = 35'sd2097149;
            5'd10:   v = 35'sd1048576;
            5'd11:   v = 35'sd524288;
            5'd12:   v = 35'sd262144;
            5'd13:   v = 35'sd131072;
            5'd14:   v = 35'sd65536;
            5'd15:   v = 35'sd32768;
            5'd16:   v = 35'sd16384;
            5'd17:   v = 35'sd8192;
            5'd18:   v = 35'sd4096;
            5'd19:   v = 35'sd2048;
            5'd20:   v = 35'sd1024;
            5'd21:   v = 35'sd512;
            5'd22:   v = 35'sd256;
            5'd23:   v = 35'sd128;
            5'd24:   v = 35'sd64;
            5'd25:   v = 35'sd32;
            5'd26:   v = 35'sd16;
            5'd27:   v = 35'sd8;
            5'd28:   v = 35'sd4;
            5'd29:   v = 35'sd2;
            5'd30:   v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/rpac_fold.sv
// Input register: center differences, Q30 angle and quadrant fold.
module rpac_fold
    import rpac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_point_x,
    input  logic signed [CW-1:0] i_point_y,
    input  logic signed [CW-1:0] i_center_x,
    input  logic signed [CW-1:0] i_center_y,
    input  logic signed [AW-1:0] i_angle,
    output logic                 o_valid,
    output t_cell                o_cell
);

    logic                 r_valid;
    t_cell                r_cell;
    t_cell                n_cell;
    logic signed [QW-1:0] w_z;

    // Angle to Q30: scale by 2^14
    assign w_z = {{(QW-AW-14){i_angle[AW-1]}}, i_angle, 14'b0};

    // Fold into [-pi/2, pi/2], form exact differences, seed the rotator
    always_comb begin
        n_cell     = '0;
        n_cell.dx  = DW'(i_point_x) - DW'(i_center_x);
        n_cell.dy  = DW'(i_point_y) - DW'(i_center_y);
        n_cell.cx  = i_center_x;
        n_cell.cy  = i_center_y;
        n_cell.x   = Q30_GAIN_INV;
        n_cell.y   = '0;
        n_cell.z   = w_z;
        n_cell.neg = 1'b0;
        if (w_z > Q30_HALF_PI) begin
            n_cell.z   = w_z - Q30_PI;
            n_cell.neg = 1'b1;
        end else if (w_z < -Q30_HALF_PI) begin
            n_cell.z   = w_z + Q30_PI;
            n_cell.neg = 1'b1;
        end
    end

    // Advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// File: src/rpac_cell.sv
// One CORDIC rotation cell: a micro-rotation by atan(2^-STAGE), registered.
module rpac_cell
    import rpac_pkg::*;
#(
    parameter int STAGE = 0
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_ce,
    input  logic  i_valid,
    input  t_cell i_cell,
    output logic  o_valid,
    output t_cell o_cell
);

    logic                 r_valid;
    t_cell                r_cell;
    t_cell                n_cell;
    logic signed [QW-1:0] w_x;
    logic signed [QW-1:0] w_y;
    logic signed [QW-1:0] w_xs;
    logic signed [QW-1:0] w_ys;
    logic signed [QW-1:0] w_atan;

    assign w_x    = i_cell.x;
    assign w_y    = i_cell.y;
    assign w_xs   = w_x >>> STAGE;
    assign w_ys   = w_y >>> STAGE;
    assign w_atan = atan_q30(5'(STAGE));

    // Rotate toward zero residual angle
    always_comb begin
        n_cell = i_cell;
        if (!i_cell.z[QW-1]) begin
            n_cell.x = w_x - w_ys;
            n_cell.y = w_y + w_xs;
            n_cell.z = i_cell.z - w_atan;
        end else begin
            n_cell.x = w_x + w_ys;
            n_cell.y = w_y - w_xs;
            n_cell.z = i_cell.z + w_atan;
        end
    end

    // Advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    // Hand payload to the next cell
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// File: src/rpac_post.sv
// Back end: coefficient rounding, rotation multiplies, rounding, saturation.
module rpac_post
    import rpac_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  t_cell                i_cell,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_rot_x,
    output logic signed [CW-1:0] o_rot_y,
    output logic                 o_overflow
);

`include "rotate_point_about_center_core_macros.svh"

    localparam int SH = 30 - FRAC_BITS;          // Q30 to coefficient shift
    localparam int KW = FRAC_BITS + 3;           // coefficient width
    localparam int PW = DW + KW;                 // product width
    localparam int SW = PW + 1;                  // product sum width
    localparam int RW = SW - FRAC_BITS;          // rounded term width
    localparam int TW = RW + 1;                  // final sum width
    localparam logic signed [QW-1:0] C_HALF = QW'(1) <<< (SH - 1);
    localparam logic signed [SW-1:0] P_HALF = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [KW-1:0] K_LIM  =
        KW'(2**FRAC_BITS + 2**(FRAC_BITS - 3));
    localparam logic signed [TW-1:0] T_MAX  = TW'(2147483647);
    localparam logic signed [TW-1:0] T_MIN  = -(TW'(1) <<< (CW - 1));
    localparam logic signed [CW-1:0] O_MAX  = CW'(2147483647);
    localparam logic signed [CW-1:0] O_MIN  = {1'b1, {(CW-1){1'b0}}};

    // Stage 1 registers: coefficients
    logic                 r_v1;
    logic signed [KW-1:0] r_c;
    logic signed [KW-1:0] r_s;
    logic signed [DW-1:0] r_dx1, r_dy1;
    logic signed [CW-1:0] r_cx1, r_cy1;
    // Stage 2 registers: products
    logic                 r_v2;
    logic signed [PW-1:0] r_p_xc, r_p_ys, r_p_xs, r_p_yc;
    logic signed [CW-1:0] r_cx2, r_cy2;
    // Stage 3 registers: rounded rotated differences
    logic                 r_v3;
    logic signed [RW-1:0] r_tx, r_ty;
    logic signed [CW-1:0] r_cx3, r_cy3;
    // Stage 4 registers: output
    logic                 r_v4;
    logic signed [CW-1:0] r_rx, r_ry;
    logic                 r_ovf;

    logic signed [QW-1:0] w_xn, w_yn, w_xr, w_yr;
    logic signed [SW-1:0] w_sx, w_sy;
    logic signed [TW-1:0] w_fx, w_fy;
    logic signed [CW-1:0] n_rx, n_ry;
    logic                 n_ovf;

    // Undo fold sign and round cosine/sine to FRAC_BITS
    assign w_xn = i_cell.neg ? -i_cell.x : i_cell.x;
    assign w_yn = i_cell.neg ? -i_cell.y : i_cell.y;
    assign w_xr = (w_xn + C_HALF) >>> SH;
    assign w_yr = (w_yn + C_HALF) >>> SH;

    // Combine products with round-half-up
    assign w_sx = (SW'(r_p_xc) - SW'(r_p_ys) + P_HALF) >>> FRAC_BITS;
    assign w_sy = (SW'(r_p_xs) + SW'(r_p_yc) + P_HALF) >>> FRAC_BITS;

    // Add center back
    assign w_fx = TW'(r_cx3) + TW'(r_tx);
    assign w_fy = TW'(r_cy3) + TW'(r_ty);

    // Clamp to 32 bits and flag
    always_comb begin
        n_ovf = 1'b0;
        n_rx  = w_fx[CW-1:0];
        n_ry  = w_fy[CW-1:0];
        if (w_fx > T_MAX) begin
            n_rx  = O_MAX;
            n_ovf = 1'b1;
        end else if (w_fx < T_MIN) begin
            n_rx  = O_MIN;
            n_ovf = 1'b1;
        end
        if (w_fy > T_MAX) begin
            n_ry  = O_MAX;
            n_ovf = 1'b1;
        end else if (w_fy < T_MIN) begin
            n_ry  = O_MIN;
            n_ovf = 1'b1;
        end
    end

    // Advance valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_c    <= w_xr[KW-1:0];
            r_s    <= w_yr[KW-1:0];
            r_dx1  <= i_cell.dx;
            r_dy1  <= i_cell.dy;
            r_cx1  <= i_cell.cx;
            r_cy1  <= i_cell.cy;

            r_p_xc <= r_dx1 * r_c;
            r_p_ys <= r_dy1 * r_s;
            r_p_xs <= r_dx1 * r_s;
            r_p_yc <= r_dy1 * r_c;
            r_cx2  <= r_cx1;
            r_cy2  <= r_cy1;

            r_tx   <= w_sx[RW-1:0];
            r_ty   <= w_sy[RW-1:0];
            r_cx3  <= r_cx2;
            r_cy3  <= r_cy2;

            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_ovf  <= n_ovf;
        end
    end

    assign o_valid    = r_v4;
    assign o_rot_x    = r_rx;
    assign o_rot_y    = r_ry;
    assign o_overflow = r_ovf;

    // The cosine coefficient stays near the unit circle
    `RPAC_ASSERT_IMP(a_coef_c_bound, i_clk, i_rst_n, r_v1, (r_c <= K_LIM) && (r_c >= -K_LIM))
    // A flagged result holds a clamped coordinate
    `RPAC_ASSERT_IMP(a_ovf_clamped, i_clk, i_rst_n, r_v4 && r_ovf, (r_rx == O_MAX) || (r_rx == O_MIN) || (r_ry == O_MAX) || (r_ry == O_MIN))

endmodule

// File: src/rotate_point_about_center_core.sv
// Top level: rotates a Q16.16 point about a center through a chain of CORDIC cells.
// Pipeline: fold register, the CORDIC_STAGES rotation cells, then the back end registers.
// Throughput: one beat per cycle unless held; unrolled cells and back end advance together.
// Backpressure: the whole pipeline holds while the output register is full and not taken.
// Reset: synchronous, active low; clears all stage valids, payload registers keep data.
module rotate_point_about_center_core
    import rpac_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // point_x, point_y, center_x, center_y, angle (lowest bits first), zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // rot_x, rot_y, overflow (lowest bits first), zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready
);

`include "rotate_point_about_center_core_macros.svh"

    logic                 w_ce;
    logic                 w_valid [CORDIC_STAGES+1];
    t_cell                w_cell  [CORDIC_STAGES+1];
    logic                 w_out_valid;
    logic signed [CW-1:0] w_rot_x;
    logic signed [CW-1:0] w_rot_y;
    logic                 w_ovf;

    // Advance everything unless a finished beat is stuck at the output
    assign w_ce       = !w_out_valid || i_m_tready;
    assign o_s_tready = w_ce;

    // Input register and quadrant fold
    rpac_fold u_fold (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (w_ce),
        .i_valid    (i_s_tvalid),
        .i_point_x  (i_s_tdata[31:0]),
        .i_point_y  (i_s_tdata[63:32]),
        .i_center_x (i_s_tdata[95:64]),
        .i_center_y (i_s_tdata[127:96]),
        .i_angle    (i_s_tdata[146:128]),
        .o_valid    (w_valid[0]),
        .o_cell     (w_cell[0])
    );

    // Chain of rotation cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        rpac_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_valid (w_valid[g]),
            .i_cell  (w_cell[g]),
            .o_valid (w_valid[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    // Multiply, round, saturate, output register
    rpac_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (w_ce),
        .i_valid    (w_valid[CORDIC_STAGES]),
        .i_cell     (w_cell[CORDIC_STAGES]),
        .o_valid    (w_out_valid),
        .o_rot_x    (w_rot_x),
        .o_rot_y    (w_rot_y),
        .o_overflow (w_ovf)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {7'b0, w_ovf, w_rot_y, w_rot_x};

    // An accepted beat enters the first stage
    `RPAC_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_s_tvalid && o_s_tready, w_valid[0])

endmodule
